### src/swfs_pkg.sv
package swfs_pkg;

  // opcode values
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] data_value;
  } swfs_in_t;

  typedef struct packed {
    logic line_driven;
    logic line_level;
    logic busy_res;
    logic value_truncated;
  } swfs_out_t;

endpackage

### src/swfs_step.sv
module swfs_step import swfs_pkg::*; #(
  parameter int DATA_BITS = 16,
  parameter int LEAD_BITS = 2,
  parameter int POS_W     = 6
) (
  input  swfs_in_t             item_i,
  input  logic                 enable_i,
  input  logic [POS_W-1:0]     pos_i,
  input  logic                 second_half_i,
  input  logic [DATA_BITS-1:0] rem_i,
  output logic [POS_W-1:0]     pos_o,
  output logic                 second_half_o,
  output logic [DATA_BITS-1:0] rem_o,
  output swfs_out_t            res_o
);

  // position map: start high levels, start low, data bits, trailer, idle
  localparam logic [POS_W-1:0] PosStartLow = POS_W'(LEAD_BITS);
  localparam logic [POS_W-1:0] PosTrail    = POS_W'(LEAD_BITS + 1 + DATA_BITS);
  localparam logic [POS_W-1:0] PosTrailHi  = POS_W'(LEAD_BITS + 2 + DATA_BITS);
  localparam logic [POS_W-1:0] PosTrailLo  = POS_W'(LEAD_BITS + 3 + DATA_BITS);
  localparam logic [POS_W-1:0] PosIdle     = POS_W'(LEAD_BITS + 5 + DATA_BITS);

  localparam logic [31:0] KeepMask = 32'hFFFF_FFFF >> (32 - DATA_BITS);

  logic driven;
  logic level;
  logic trunc;

  always_comb begin
    pos_o         = pos_i;
    second_half_o = second_half_i;
    rem_o         = rem_i;
    driven        = 1'b0;
    level         = 1'b0;
    trunc         = 1'b0;

    if (item_i.opcode == OP_SEND) begin
      if (enable_i) begin
        trunc         = |(item_i.data_value & ~KeepMask);
        rem_o         = item_i.data_value[DATA_BITS-1:0];
        second_half_o = 1'b0;
        pos_o         = '0;
      end
    end else if (pos_i < PosStartLow) begin
      driven = 1'b1;
      level  = 1'b1;
      pos_o  = pos_i + POS_W'(1);
    end else if (pos_i == PosStartLow) begin
      driven = 1'b1;
      pos_o  = pos_i + POS_W'(1);
    end else if (pos_i < PosTrail) begin
      // data bits shift out lsb first; stop early once nothing is left
      driven = 1'b1;
      if (!second_half_i) begin
        level         = rem_i[0];
        rem_o[0]      = 1'b0;
        second_half_o = 1'b1;
      end else begin
        rem_o         = rem_i >> 1;
        pos_o         = (rem_i == '0) ? PosTrail : pos_i + POS_W'(1);
        second_half_o = 1'b0;
      end
    end else if (pos_i == PosTrail || pos_i == PosTrailLo) begin
      driven = 1'b1;
      pos_o  = pos_i + POS_W'(1);
    end else if (pos_i == PosTrailHi) begin
      driven = 1'b1;
      level  = 1'b1;
      pos_o  = pos_i + POS_W'(1);
    end else begin
      pos_o = PosIdle;
    end
  end

  assign res_o.line_driven     = driven;
  assign res_o.line_level      = level;
  assign res_o.busy_res        = (pos_o != PosIdle);
  assign res_o.value_truncated = trunc;

endmodule

### src/single_wire_frame_serializer_top.sv
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle unless the output stalls; the single result register frees itself
//   in the same cycle its result is taken, so input and output overlap
// reset: asynchronous active-low; enable comes up set, the line position
//   comes up idle (nothing driven), data bits and half-bit flag cleared
module single_wire_frame_serializer_top import swfs_pkg::*; #(
  parameter int DATA_BITS = 16,
  parameter int LEAD_BITS = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration: single enable register
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  // item input
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  swfs_in_t  in_data_i,
  // result output
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output swfs_out_t out_data_o
);

  // position counts from the first start level up to idle
  localparam int POS_IDLE = LEAD_BITS + 5 + DATA_BITS;
  localparam int POS_W    = $clog2(POS_IDLE + 1);

  localparam logic [POS_W-1:0] PosIdle  = POS_W'(POS_IDLE);
  localparam logic [POS_W-1:0] PosData  = POS_W'(LEAD_BITS + 1);
  localparam logic [POS_W-1:0] PosTrail = POS_W'(LEAD_BITS + 1 + DATA_BITS);

  // frame state
  logic                 enable_q;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 second_half_q, second_half_d;
  logic [DATA_BITS-1:0] rem_q, rem_d;

  // result register
  logic      out_valid_q;
  swfs_out_t out_data_q;
  swfs_out_t res_d;

  logic in_fire;

  // config writes land at once; no backpressure needed
  assign cfg_ready_o = 1'b1;

  // take a new item whenever the result slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // next-state and result for the item at the input
  swfs_step #(
    .DATA_BITS (DATA_BITS),
    .LEAD_BITS (LEAD_BITS),
    .POS_W     (POS_W)
  ) u_step (
    .item_i        (in_data_i),
    .enable_i      (enable_q),
    .pos_i         (pos_q),
    .second_half_i (second_half_q),
    .rem_i         (rem_q),
    .pos_o         (pos_d),
    .second_half_o (second_half_d),
    .rem_o         (rem_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // state moves only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= PosIdle;
      second_half_q <= 1'b0;
      rem_q         <= '0;
    end else if (in_fire) begin
      pos_q         <= pos_d;
      second_half_q <= second_half_d;
      rem_q         <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // position never runs past idle
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosIdle)
    else $error("frame position out of range");

  // the half-bit flag is only ever set inside the data section
  a_half_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_half_q |-> (pos_q >= PosData && pos_q < PosTrail))
    else $error("half-bit flag set outside data section");

  // an enabled send restarts the frame at its first start level
  a_send_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.opcode == OP_SEND && enable_q)
      |=> (pos_q == '0 && !second_half_q))
    else $error("send did not restart the frame");

  // a truncation flag only comes with a send result, which drives nothing
  a_trunc_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.value_truncated)
      |-> (out_data_o.busy_res && !out_data_o.line_driven))
    else $error("truncation flag on a non-send result");

endmodule

### verif/tb_single_wire_frame_serializer_top.sv
`timescale 1ns / 1ps

module tb_single_wire_frame_serializer_top;
  import swfs_pkg::*;

  localparam int DATA_BITS = 16;
  localparam int LEAD_BITS = 2;
  // frame position once the trailer is done and the line is released
  localparam int POS_IDLE = DATA_BITS + 4;
  localparam logic [63:0] WIDE_MASK = (64'd1 << DATA_BITS) - 64'd1;
  localparam logic [31:0] VALUE_KEEP = WIDE_MASK[31:0];

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  swfs_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  swfs_out_t out_data_o;

  // items waiting for the driver, and line results waiting for the monitor
  swfs_in_t  tx_pending[$];
  swfs_out_t level_expected[$];
  int        fail_count = 0;
  // set for a stretch of traffic with no idling on either side
  bit        steady = 1'b0;

  // shadow of the serializer: enable register and frame state
  logic        cfg_enable   = 1'b1;
  int          frame_pos    = POS_IDLE;
  bit          second_half  = 1'b0;
  logic [31:0] pending_bits = '0;

  single_wire_frame_serializer_top #(
    .DATA_BITS(DATA_BITS),
    .LEAD_BITS(LEAD_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // advance the shadow frame by one item and return the line result it causes
  function automatic swfs_out_t serialize_step(swfs_in_t item);
    swfs_out_t res;
    logic [31:0] kept;
    res = '0;
    if (item.opcode == OP_SEND) begin
      // a send restarts the frame; ignored while disabled
      if (cfg_enable) begin
        kept = item.data_value & VALUE_KEEP;
        res.value_truncated = (kept != item.data_value);
        pending_bits = kept;
        second_half = 1'b0;
        frame_pos = -LEAD_BITS - 1;
      end
    end else if (frame_pos < 0) begin
      // start section: high levels, then one low
      res.line_driven = 1'b1;
      res.line_level = (frame_pos != -1);
      frame_pos++;
    end else if (frame_pos < DATA_BITS) begin
      // data bit: value tick, then low tick; stop once no set bits remain
      res.line_driven = 1'b1;
      if (!second_half) begin
        if (pending_bits[frame_pos]) begin
          res.line_level = 1'b1;
          pending_bits[frame_pos] = 1'b0;
        end
        second_half = 1'b1;
      end else begin
        frame_pos = (pending_bits == '0) ? DATA_BITS : frame_pos + 1;
        second_half = 1'b0;
      end
    end else if (frame_pos < DATA_BITS + 3) begin
      // trailer low, high, low
      res.line_driven = 1'b1;
      res.line_level = (frame_pos == DATA_BITS + 1);
      frame_pos++;
    end else begin
      // undriven tail tick, or idle
      frame_pos = POS_IDLE;
    end
    res.busy_res = (frame_pos != POS_IDLE);
    return res;
  endfunction

  function automatic void push_item(logic op, logic [31:0] value);
    tx_pending.push_back(swfs_in_t'{opcode: op, data_value: value});
  endfunction

  function automatic void field_check(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endfunction

  // mostly whole frames (send, then enough ticks to finish, sometimes cut
  // short by the next send), with some random items mixed in
  task automatic queue_traffic(int n_items);
    int left;
    int width;
    int hi;
    int span;
    logic [31:0] value;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(99) < 85) begin
        width = ($urandom_range(3) == 0) ? $urandom_range(17, 32) : $urandom_range(0, 16);
        value = (width == 0) ? '0 : ($urandom() >> (32 - width));
        hi = 0;
        for (int b = 0; b < DATA_BITS; b++) if (value[b]) hi = b;
        span = LEAD_BITS + 1 + 2 * (hi + 1) + 4 + $urandom_range(3);
        if ($urandom_range(4) == 0) span = $urandom_range(1, span);
        push_item(OP_SEND, value);
        repeat (span) push_item(OP_TICK, $urandom());
        left -= span + 1;
      end else begin
        push_item(logic'($urandom_range(1)), $urandom());
        left--;
      end
    end
  endtask

  // wait until every queued item went in and every result came back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (tx_pending.size() != 0 || in_valid_i || level_expected.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_enable(logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_enable = value;
  endtask

  // driver: predict on acceptance, then offer the next item unless idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) level_expected.push_back(serialize_step(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (tx_pending.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          in_valid_i <= 1'b1;
          in_data_i <= tx_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    swfs_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (level_expected.size() == 0) begin
          $error("result with no item outstanding: %b", out_data_o);
          fail_count++;
        end else begin
          want = level_expected.pop_front();
          field_check("line_driven", want.line_driven, out_data_o.line_driven);
          field_check("line_level", want.line_level, out_data_o.line_level);
          field_check("busy_res", want.busy_res, out_data_o.busy_res);
          field_check("value_truncated", want.value_truncated, out_data_o.value_truncated);
        end
      end
      out_ready_i <= steady || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, zero value frame run to idle
    push_item(OP_TICK, 32'h0000_0000);
    push_item(OP_SEND, 32'h0000_0000);
    repeat (10) push_item(OP_TICK, 32'hFFFF_FFFF);
    // truncated all-ones value, cut off by a frame using the top data bit
    push_item(OP_SEND, 32'hFFFF_FFFF);
    repeat (3) push_item(OP_TICK, 32'h0000_0000);
    push_item(OP_SEND, 32'h0001_8000);
    repeat (5) push_item(OP_TICK, 32'h5555_AAAA);
    wait_quiet();

    // disable mid-frame: ticks finish the frame, sends are dropped
    write_enable(1'b0);
    queue_traffic(150);
    wait_quiet();

    write_enable(1'b1);
    queue_traffic(600);
    wait_quiet();

    write_enable(1'b0);
    queue_traffic(100);
    wait_quiet();

    // back-to-back stretch with no idling on either side
    write_enable(1'b1);
    steady = 1'b1;
    queue_traffic(500);
    wait_quiet();
    steady = 1'b0;

    queue_traffic(150);
    wait_quiet();

    if (level_expected.size() != 0) begin
      $error("%0d results never arrived", level_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_single_wire_frame_serializer_top: clean");
    end else begin
      $display("tb_single_wire_frame_serializer_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_single_wire_frame_serializer_top: errors");
    $finish;
  end

endmodule
